// ===== src/banked_register_file_mode_switch_defines.svh =====
// ----------------------------------------------------------------------------
// Banked register file - assertion macros
// Shared property wrappers; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BANKED_REGISTER_FILE_MODE_SWITCH_DEFINES_SVH
`define BANKED_REGISTER_FILE_MODE_SWITCH_DEFINES_SVH

// same-cycle implication
`define BRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brf assertion failed");

// next-cycle implication
`define BRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brf assertion failed");

`endif

// ===== src/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Types, constants and helpers of the banked register file.
// ----------------------------------------------------------------------------
package brf_pkg;

  localparam int CMD_W  = 3;
  localparam int IDX_W  = 4;
  localparam int DATA_W = 32;
  localparam int MODE_W = 5;
  localparam int NREGS  = 16;
  localparam int NFIQ   = 7;
  localparam int NSMALL = 4;
  localparam int T_IDX  = 5;
  localparam int I_IDX  = 7;

  localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
  localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
  localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
  localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
  localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;

  localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_00D3;
  localparam logic [7:0]        IRQ_BYTE     = 8'hD2;
  localparam logic [DATA_W-1:0] HIGH_VEC     = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] IRQ_VEC      = 32'h0000_0018;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_STATUS = 3'd2,
    CMD_SAVED  = 3'd3,
    CMD_JUMP   = 3'd4,
    CMD_IRQ    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP_OLD,
    S_SWAP_NEW,
    S_FINISH,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_EXEC,
    OP_SWAP_OLD,
    OP_SWAP_NEW,
    OP_FINISH,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_chg;
  } dp_stat_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] data;
    logic              restore_flag;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic [DATA_W-1:0] status_out;
    logic              fetch_valid;
    logic [DATA_W-1:0] fetch_address;
    logic              fetch_halfword;
    logic              irq_taken;
    logic              bad_mode;
  } result_t;

  function automatic logic is_small(input logic [MODE_W-1:0] m);
    return (m == MODE_IRQ) || (m == MODE_SVC) || (m == MODE_ABT) || (m == MODE_UND);
  endfunction

  function automatic logic [1:0] small_slot(input logic [MODE_W-1:0] m);
    logic [1:0] s;
    case (m)
      MODE_IRQ: s = 2'd0;
      MODE_SVC: s = 2'd1;
      MODE_ABT: s = 2'd2;
      MODE_UND: s = 2'd3;
      default:  s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== src/brf_in_if.sv =====
// ----------------------------------------------------------------------------
// brf_in_if
// Command channel: valid/ready handshake with one command word.
// ----------------------------------------------------------------------------
interface brf_in_if;
  logic                       valid;
  logic                       ready;
  logic [brf_pkg::CMD_W-1:0]  command;
  logic [brf_pkg::IDX_W-1:0]  reg_index;
  logic [brf_pkg::DATA_W-1:0] data;
  logic                       restore_flag;

  modport source (output valid, command, reg_index, data, restore_flag, input ready);
  modport sink   (input valid, command, reg_index, data, restore_flag, output ready);
endinterface

// ===== src/brf_out_if.sv =====
// ----------------------------------------------------------------------------
// brf_out_if
// Result channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface brf_out_if;
  logic                       valid;
  logic                       ready;
  logic [brf_pkg::DATA_W-1:0] read_data;
  logic [brf_pkg::DATA_W-1:0] status_out;
  logic                       fetch_valid;
  logic [brf_pkg::DATA_W-1:0] fetch_address;
  logic                       fetch_halfword;
  logic                       irq_taken;
  logic                       bad_mode;

  modport source (output valid, read_data, status_out, fetch_valid, fetch_address,
                  fetch_halfword, irq_taken, bad_mode, input ready);
  modport sink   (input valid, read_data, status_out, fetch_valid, fetch_address,
                  fetch_halfword, irq_taken, bad_mode, output ready);
endinterface

// ===== src/banked_register_file_mode_switch.sv =====
// Sequence per command word: accept and load, execute, then, when the mode field changes,
// bank swap (the old bank swaps out, then the new one swaps in), fetch update and publish.
// Publish waits while the last result is still held; a new command word is accepted only in idle.
// The result register lets a new word be accepted while the last result waits.
// Reset (synchronous, rst_n low): registers and banks zero, R15 = 0xFFFF0004,
// status 0xD3 (supervisor), vectors high.
// ----------------------------------------------------------------------------
// banked_register_file_mode_switch
// Mode-banked register file with status switching, jumps and irq entry.
// ----------------------------------------------------------------------------
`include "banked_register_file_mode_switch_defines.svh"

module banked_register_file_mode_switch (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_if,
  brf_out_if.source out_if,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import brf_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  item_t    item;
  result_t  res;

  assign item.command      = in_if.command;
  assign item.reg_index    = in_if.reg_index;
  assign item.data         = in_if.data;
  assign item.restore_flag = in_if.restore_flag;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .stat      (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  brf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .stat      (dp_stat),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  assign out_if.read_data      = res.read_data;
  assign out_if.status_out     = res.status_out;
  assign out_if.fetch_valid    = res.fetch_valid;
  assign out_if.fetch_address  = res.fetch_address;
  assign out_if.fetch_halfword = res.fetch_halfword;
  assign out_if.irq_taken      = res.irq_taken;
  assign out_if.bad_mode       = res.bad_mode;

  `BRF_ASSERT_NXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready)
  `BRF_ASSERT_IMP(a_irq_entry, out_if.valid && out_if.irq_taken,
                  out_if.fetch_valid && (out_if.status_out[7:0] == IRQ_BYTE))
  `BRF_ASSERT_IMP(a_thumb_fetch, out_if.valid && out_if.fetch_halfword,
                  out_if.fetch_valid && out_if.status_out[T_IDX])
  `BRF_ASSERT_IMP(a_no_fetch_addr, out_if.valid && !out_if.fetch_valid,
                  (out_if.fetch_address == '0) && !out_if.fetch_halfword)

endmodule

// ===== src/brf_ctrl.sv =====
// ----------------------------------------------------------------------------
// brf_ctrl
// Sequencer: load, execute, bank swap out/in, fetch update, publish.
// ----------------------------------------------------------------------------
module brf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  brf_pkg::dp_stat_t  stat,
  output brf_pkg::dp_cmd_t   dp_cmd
);
  import brf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dp_cmd.op     = OP_NONE;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.op = OP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        dp_cmd.op = OP_EXEC;
        state_nxt = S_SWAP_OLD;
      end
      S_SWAP_OLD: begin
        if (stat.mode_chg) begin
          dp_cmd.op = OP_SWAP_OLD;
          state_nxt = S_SWAP_NEW;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SWAP_NEW: begin
        dp_cmd.op = OP_SWAP_NEW;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        dp_cmd.op = OP_FINISH;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.op     = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/brf_dp.sv =====
// ----------------------------------------------------------------------------
// brf_dp
// Register file, mode banks, status word and result register.
// ----------------------------------------------------------------------------
module brf_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  brf_pkg::dp_cmd_t  dp_cmd,
  output brf_pkg::dp_stat_t stat,
  input  brf_pkg::item_t    item,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  output brf_pkg::result_t  res
);
  import brf_pkg::*;

  logic [DATA_W-1:0] regs_r [NREGS];
  logic [DATA_W-1:0] fiq_r [NFIQ];
  logic [DATA_W-1:0] fiq_spsr_r;
  logic [DATA_W-1:0] ob13_r [NSMALL];
  logic [DATA_W-1:0] ob14_r [NSMALL];
  logic [DATA_W-1:0] obsp_r [NSMALL];
  logic [DATA_W-1:0] status_r;
  logic              core_sel_r;

  cmd_t              cmd_r;
  logic [IDX_W-1:0]  idx_r;
  logic [DATA_W-1:0] data_r;
  logic              restore_r;
  logic [DATA_W-1:0] oldw_r;

  logic [DATA_W-1:0] rd_r, fa_r;
  logic              fv_r, fh_r, taken_r, bad_r;
  result_t           res_r;

  logic [MODE_W-1:0] cur_mode, swap_mode;
  logic              sv_fiq, sv_small, has_saved;
  logic [1:0]        sv_slot, sw_slot;
  logic [DATA_W-1:0] saved_val, vbase, jt, j_addr, j_pc;
  logic              j_thumb, do_fetch;

  always_comb begin
    cur_mode  = status_r[MODE_W-1:0];
    sv_fiq    = (cur_mode == MODE_FIQ);
    sv_small  = is_small(cur_mode);
    sv_slot   = small_slot(cur_mode);
    has_saved = sv_fiq || sv_small;
    saved_val = sv_fiq ? fiq_spsr_r : obsp_r[sv_slot];
    swap_mode = (dp_cmd.op == OP_SWAP_OLD) ? oldw_r[MODE_W-1:0] : cur_mode;
    sw_slot   = small_slot(swap_mode);
    vbase     = core_sel_r ? '0 : HIGH_VEC;
    if (cmd_r == CMD_JUMP) begin
      jt = restore_r ? {data_r[DATA_W-1:1], status_r[T_IDX]} : data_r;
    end else begin
      jt = vbase + IRQ_VEC;
    end
    j_thumb  = jt[0];
    j_addr   = j_thumb ? {jt[DATA_W-1:1], 1'b0} : {jt[DATA_W-1:2], 2'b00};
    j_pc     = j_addr + (j_thumb ? 32'd2 : 32'd4);
    do_fetch = (cmd_r == CMD_JUMP) || ((cmd_r == CMD_IRQ) && taken_r);
  end

  assign stat.mode_chg = (oldw_r[MODE_W-1:0] != status_r[MODE_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREGS-1; i++) regs_r[i] <= '0;
      regs_r[NREGS-1] <= HIGH_VEC + 32'd4;
      for (int i = 0; i < NFIQ; i++) fiq_r[i] <= '0;
      for (int i = 0; i < NSMALL; i++) begin
        ob13_r[i] <= '0;
        ob14_r[i] <= '0;
        obsp_r[i] <= '0;
      end
      fiq_spsr_r <= '0;
      status_r   <= STATUS_RESET;
      core_sel_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        core_sel_r <= cfg_wdata;
      end
      case (dp_cmd.op)
        OP_EXEC: begin
          case (cmd_r)
            CMD_WRITE:  regs_r[idx_r] <= data_r;
            CMD_STATUS: status_r <= data_r;
            CMD_SAVED: begin
              if (sv_fiq) begin
                fiq_spsr_r <= data_r;
              end else if (sv_small) begin
                obsp_r[sv_slot] <= data_r;
              end
            end
            CMD_JUMP: begin
              if (restore_r && has_saved) begin
                status_r <= saved_val;
              end
            end
            CMD_IRQ: begin
              if (!status_r[I_IDX]) begin
                status_r  <= {status_r[DATA_W-1:8], IRQ_BYTE};
                obsp_r[0] <= status_r;
              end
            end
            default: ;
          endcase
        end
        OP_SWAP_OLD, OP_SWAP_NEW: begin
          if (swap_mode == MODE_FIQ) begin
            for (int i = 0; i < NFIQ; i++) begin
              regs_r[8+i] <= fiq_r[i];
              fiq_r[i]    <= regs_r[8+i];
            end
          end else if (is_small(swap_mode)) begin
            regs_r[13]      <= ob13_r[sw_slot];
            regs_r[14]      <= ob14_r[sw_slot];
            ob13_r[sw_slot] <= regs_r[13];
            ob14_r[sw_slot] <= regs_r[14];
          end
        end
        OP_FINISH: begin
          if (do_fetch) begin
            if (cmd_r == CMD_IRQ) begin
              regs_r[14] <= regs_r[15] + (oldw_r[T_IDX] ? 32'd2 : 32'd0);
            end
            regs_r[15]      <= j_pc;
            status_r[T_IDX] <= j_thumb;
          end
        end
        default: ;
      endcase
    end
  end

  // per-word scratch and result register
  always_ff @(posedge clk) begin
    case (dp_cmd.op)
      OP_LOAD: begin
        cmd_r     <= cmd_t'(item.command);
        idx_r     <= item.reg_index;
        data_r    <= item.data;
        restore_r <= item.restore_flag;
        oldw_r    <= status_r;
        rd_r      <= '0;
        fa_r      <= '0;
        fv_r      <= 1'b0;
        fh_r      <= 1'b0;
        taken_r   <= 1'b0;
        bad_r     <= 1'b0;
      end
      OP_EXEC: begin
        if (cmd_r == CMD_READ) begin
          rd_r <= regs_r[idx_r];
        end
        if ((cmd_r == CMD_JUMP) && restore_r && !has_saved) begin
          bad_r <= 1'b1;
        end
        if ((cmd_r == CMD_IRQ) && !status_r[I_IDX]) begin
          taken_r <= 1'b1;
        end
      end
      OP_FINISH: begin
        if (do_fetch) begin
          fv_r <= 1'b1;
          fa_r <= j_addr;
          fh_r <= j_thumb;
        end
      end
      OP_PUBLISH: begin
        res_r.read_data      <= rd_r;
        res_r.status_out     <= status_r;
        res_r.fetch_valid    <= fv_r;
        res_r.fetch_address  <= fa_r;
        res_r.fetch_halfword <= fh_r;
        res_r.irq_taken      <= taken_r;
        res_r.bad_mode       <= bad_r;
      end
      default: ;
    endcase
  end

  assign res = res_r;

endmodule
